/* rtl/core/ssd_pkg.sv */
package ssd_pkg;

  localparam int NumDigits = 8;
  localparam int PosW      = $clog2(NumDigits);
  localparam int CodeW     = 5;
  localparam int SwW       = 16;
  localparam int BtnW      = 5;
  localparam int SegW      = 8;
  localparam int BcdW      = 20;

  typedef logic [CodeW-1:0] code_t;

  typedef enum logic {
    OP_BUTTON = 1'b0,
    OP_SCAN   = 1'b1
  } op_e;

  localparam logic [BtnW-1:0] BtnBinary = 5'h01;
  localparam logic [BtnW-1:0] BtnHex    = 5'h02;
  localparam logic [BtnW-1:0] BtnDec    = 5'h10;

  localparam code_t          BlankCode = 5'd16;
  localparam logic [SegW-1:0] SegBlank = 8'hff;
  localparam logic [NumDigits-1:0] SelLeft = 8'h80;

  typedef struct packed {
    op_e             op;
    logic [BtnW-1:0] buttons;
    logic [SwW-1:0]  switches;
  } in_beat_t;

  typedef struct packed {
    logic [NumDigits-1:0] digit_select;
    logic [SegW-1:0]      segments;
    logic [PosW-1:0]      position;
  } out_beat_t;

  // button beat handed to the digit store
  typedef struct packed {
    logic            valid;
    logic [BtnW-1:0] buttons;
    logic [SwW-1:0]  switches;
  } ssd_event_t;

  function automatic logic [SegW-1:0] glyph(input code_t code);
    logic [SegW-1:0] seg;
    unique case (code)
      5'd0:    seg = 8'hc0;
      5'd1:    seg = 8'hf9;
      5'd2:    seg = 8'ha4;
      5'd3:    seg = 8'hb0;
      5'd4:    seg = 8'h99;
      5'd5:    seg = 8'h92;
      5'd6:    seg = 8'h82;
      5'd7:    seg = 8'hf8;
      5'd8:    seg = 8'h80;
      5'd9:    seg = 8'h90;
      5'd10:   seg = 8'h88;
      5'd11:   seg = 8'h83;
      5'd12:   seg = 8'hc6;
      5'd13:   seg = 8'ha1;
      5'd14:   seg = 8'h86;
      5'd15:   seg = 8'h8e;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

endpackage

/* rtl/core/ssd_digits.sv */
module ssd_digits import ssd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ssd_event_t ev_i,
  output code_t      codes_o [NumDigits]
);

  localparam int HalfW = SwW / 2;

  // eight shift-and-add-3 steps of the binary to bcd conversion
  function automatic logic [BcdW-1:0] dabble8(input logic [BcdW-1:0] bcd_in,
                                              input logic [HalfW-1:0] bits);
    logic [BcdW-1:0] bcd;
    bcd = bcd_in;
    for (int i = HalfW - 1; i >= 0; i--) begin
      for (int d = 0; d < BcdW / 4; d++) begin
        if (bcd[d*4 +: 4] >= 4'd5) begin
          bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
        end
      end
      bcd = {bcd[BcdW-2:0], bits[i]};
    end
    return bcd;
  endfunction

  code_t            codes_q [NumDigits];
  code_t            codes_d [NumDigits];
  logic             dec_vld_q, dec_vld_d;
  logic [BcdW-1:0]  dec_bcd_q, dec_bcd_d;
  logic [HalfW-1:0] dec_low_q;
  logic [BcdW-1:0]  bcd_full;
  logic             start_dec;

  assign start_dec = ev_i.valid && (ev_i.buttons == BtnDec);
  assign dec_vld_d = start_dec;
  assign dec_bcd_d = dabble8('0, ev_i.switches[SwW-1:HalfW]);
  assign bcd_full  = dabble8(dec_bcd_q, dec_low_q);

  always_comb begin
    codes_d = codes_q;
    if (ev_i.valid && ev_i.buttons == BtnBinary) begin
      for (int k = 0; k < NumDigits; k++) begin
        codes_d[k] = {4'd0, ev_i.switches[NumDigits-1-k]};
      end
    end else if (ev_i.valid && ev_i.buttons == BtnHex) begin
      for (int k = 0; k < 4; k++) begin
        codes_d[k] = BlankCode;
      end
      for (int k = 0; k < 4; k++) begin
        codes_d[4+k] = {1'b0, ev_i.switches[(3-k)*4 +: 4]};
      end
    end
    // second conversion stage lands the five decimal digits
    if (dec_vld_q) begin
      for (int k = 0; k < 3; k++) begin
        codes_d[k] = BlankCode;
      end
      for (int k = 0; k < 5; k++) begin
        codes_d[3+k] = {1'b0, bcd_full[(4-k)*4 +: 4]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumDigits; k++) begin
        codes_q[k] <= '0;
      end
      dec_vld_q <= 1'b0;
    end else begin
      codes_q   <= codes_d;
      dec_vld_q <= dec_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_dec) begin
      dec_bcd_q <= dec_bcd_d;
      dec_low_q <= ev_i.switches[HalfW-1:0];
    end
  end

  assign codes_o = codes_q;

endmodule

/* rtl/core/switch_value_seven_segment_display_top.sv */
// Eight-digit multiplexed seven-segment controller. A button beat (op = 0)
// rewrites the digit store: buttons 0x01 shows switch bits 7..0 as binary
// digits, 0x02 shows four hex nibbles right-aligned, 0x10 shows five decimal
// digits right-aligned, any other value is ignored; button beats give no
// result. A scan beat (op = 1) returns the active-low digit select, segment
// pattern and position for the current digit, then moves to the next one.
// One beat is taken per clock while in_stall_o is low. A scan result passes
// its input register and lands in an output register, where it sits, so
// button beats keep flowing while a result waits, and a scan beat behind a
// waiting result holds the input until the result is taken. A 0x10 button
// beat holds in_stall_o high while it is in the input register, since decimal
// conversion runs over two register stages before the digit store is written.
module switch_value_seven_segment_display_top import ssd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  in_beat_t        in_q;
  logic            in_vld_q, in_vld_d;
  out_beat_t       out_q, out_d;
  logic            out_vld_q, out_vld_d;
  logic [PosW-1:0] pos_q, pos_d;
  code_t           codes [NumDigits];
  ssd_event_t      ev;
  logic            is_scan, is_dec, out_ready, in_go, scan_go, accept;

  assign is_scan   = (in_q.op == OP_SCAN);
  assign is_dec    = !is_scan && (in_q.buttons == BtnDec);
  assign out_ready = !out_vld_q || !out_stall_i;
  assign in_go     = in_vld_q && (!is_scan || out_ready);
  assign scan_go   = in_go && is_scan;
  assign in_stall_o = in_vld_q && (!in_go || is_dec);
  assign accept    = in_valid_i && !in_stall_o;

  assign ev.valid    = in_go && !is_scan;
  assign ev.buttons  = in_q.buttons;
  assign ev.switches = in_q.switches;

  ssd_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ev_i    (ev),
    .codes_o (codes)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (in_go) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    pos_d     = pos_q;
    if (scan_go) begin
      out_vld_d = 1'b1;
      pos_d     = pos_q + 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_d.digit_select = ~(SelLeft >> pos_q);
    out_d.segments     = glyph(codes[pos_q]);
    out_d.position     = pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pos_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      pos_q     <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (scan_go) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/ssd_checker.sv */
module ssd_checker import ssd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_beat_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // digit select matches the reported position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.digit_select == ~(SelLeft >> out_data_o.position))
    else $error("digit select does not match position");

  // a scan beat taken with the output empty leads to a result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.op == OP_SCAN && !out_valid_o
    |=> ##1 out_valid_o)
    else $error("scan beat gave no result");

  // with the output empty, input stall lasts a single cycle at most
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_stall_o |=> !in_stall_o)
    else $error("input stalled without output backpressure");

endmodule

bind switch_value_seven_segment_display_top ssd_checker u_ssd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
